[rtl/iir6_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir6_pkg: shared constants for the sixth-order IIR filter
// Register map, coefficient format, multiplier width and output gain.
// ----------------------------------------------------------------------------
package iir6_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_FILTER_ORDER = 6;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // Coefficients are signed Q6.18 in 24 bits, two packed per register.
   localparam int COEF_W     = 24;
   localparam int CSR_DATA_W = 2 * COEF_W;
   localparam int NUM_CSR    = 7;
   localparam int CSR_IDX_W  = 3;

   // Flat coefficient list: b0..b6 at 0..6, a1..a6 at 7..12.
   localparam int NUM_COEF    = 13;
   localparam int COEF_SEL_W  = 4;
   localparam int COEF_A1_SEL = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_B0_B1 = 3'd0,
      CSR_COEF_B2_B3 = 3'd1,
      CSR_COEF_B4_B5 = 3'd2,
      CSR_COEF_B6_A1 = 3'd3,
      CSR_COEF_A2_A3 = 3'd4,
      CSR_COEF_A4_A5 = 3'd5,
      CSR_COEF_A6    = 3'd6
   } csr_idx_type;

   // b0 = 1.0 after reset, every other coefficient zero.
   localparam logic [CSR_DATA_W-1:0] COEF_B0_B1_RESET = 48'd262144;

   // Shared signed multiplier operand width; covers coefficients, samples
   // up to 24 bits, accumulator chunks and the gain.
   localparam int MUL_W   = 25;
   localparam int MUL_P_W = 2 * MUL_W;

   // Output gain 0.9 as 58982 / 2^16, and the accumulator chunk size used
   // when applying it.
   localparam int GAIN_NUM = 58982;
   localparam int CHUNK_W  = 24;

   // Accumulator is Q.33; gain adds 16 fractional bits: shift by 34 to Q1.15.
   localparam int OUT_SHIFT = 34;

endpackage

[rtl/iir_sixth_order_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_sixth_order_filter: direct-form-I IIR filter with output gain of 0.9
// Usage:
//   req_*  input samples; a transfer happens when req_valid is high and
//          req_stall is low. req_stall stays high while a sample is in work.
//   rsp_*  filtered samples, one per input sample, held in an output
//          register until the receiver takes it (rsp_valid high, rsp_stall
//          low). A new input is taken while a finished result still waits.
//   csr_*  coefficient writes, always ready; write only while idle.
//          Index 7 is ignored.
// Timing: one multiplier serves all taps and the gain. A sample passes through
//   the states MAC (2*FILTER_ORDER+1 tap products), DRAIN, SCALE
//   (ceil((SAMPLE_WIDTH+28)/24) gain products), SDRAIN and FINISH; no new
//   input is taken before it is done. If the previous
//   result is still stalled when the next one is done, the block holds it
//   and does not take new input until the output register frees up.
// Reset: synchronous; clears both histories to zero and sets b0 = 1.0 with
//   all other coefficients zero.
// ----------------------------------------------------------------------------
module iir_sixth_order_filter #(
   parameter int FILTER_ORDER = iir6_pkg::DEF_FILTER_ORDER,
   parameter int SAMPLE_WIDTH = iir6_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   input  logic                                 req_block_end_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   output logic                                 rsp_block_end_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iir6_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iir6_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import iir6_pkg::*;

   localparam int NTAPS  = 2 * FILTER_ORDER + 1;
   localparam int TAP_W  = $clog2(NTAPS);
   localparam int HIDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
   localparam int ACC_W  = SAMPLE_WIDTH + COEF_W + 4;
   localparam int NCHUNK = (ACC_W + CHUNK_W - 1) / CHUNK_W;
   localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W  = NCHUNK * CHUNK_W;
   localparam int PROD_W = PAD_W + 17;
   localparam int Y_W    = PROD_W - OUT_SHIFT;

   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      {{(PROD_W-OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT-1){1'b0}}};
   localparam logic signed [MUL_W-1:0] GAIN_OP = MUL_W'(GAIN_NUM);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_SDRAIN,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] coef_ff [NUM_CSR];

   // Sequencer and output register.
   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                            rsp_be_ff, rsp_be_in;
   logic [TAP_W-1:0]                tap_ff, tap_in;
   logic [CH_W-1:0]                 chunk_ff, chunk_in;
   logic                            mac_tag_ff, mac_tag_in;
   logic                            scl_tag_ff, scl_tag_in;

   // Datapath.
   logic signed [SAMPLE_WIDTH-1:0]  x_ff, x_in;
   logic                            be_ff, be_in;
   logic signed [SAMPLE_WIDTH-1:0]  xh_ff [FILTER_ORDER];
   logic signed [SAMPLE_WIDTH-1:0]  yh_ff [FILTER_ORDER];
   logic                            hist_shift;
   logic signed [MUL_P_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [PAD_W-1:0]         sr_ff, sr_in;
   logic signed [PROD_W-1:0]        p_ff, p_in;

   logic signed [COEF_W-1:0]        coef_arr [NUM_COEF];
   logic [COEF_SEL_W-1:0]           coef_sel;
   logic [TAP_W-1:0]                xh_idx, yh_idx;
   logic signed [SAMPLE_WIDTH-1:0]  samp_sel;
   logic signed [MUL_W-1:0]         mul_a, mul_b;
   logic signed [PROD_W-1:0]        p_round;
   logic signed [Y_W-1:0]           y_wide;
   logic signed [SAMPLE_WIDTH-1:0]  y_sat;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_block_end_out = rsp_be_ff;
   assign csr_ready         = 1'b1;

   // Coefficient registers. The last register holds a single coefficient.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[CSR_COEF_B0_B1] <= COEF_B0_B1_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_COEF_A6) begin
            coef_ff[CSR_COEF_A6] <= {{COEF_W{1'b0}}, csr_wdata[COEF_W-1:0]};
         end else if (int'(csr_index) < NUM_CSR) begin
            coef_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // Unpack into the flat b0..b6, a1..a6 list.
   always_comb begin
      for (int k = 0; k < NUM_COEF; k++) begin
         if (k[0]) begin
            coef_arr[k] = coef_ff[k >> 1][CSR_DATA_W-1:COEF_W];
         end else begin
            coef_arr[k] = coef_ff[k >> 1][COEF_W-1:0];
         end
      end
   end

   // Tap t: 0 is b0*x, 1..N are bk*x[n-k], N+1..2N are ak*y[n-k].
   always_comb begin
      xh_idx = tap_ff - TAP_W'(1);
      yh_idx = tap_ff - TAP_W'(FILTER_ORDER + 1);
      if (tap_ff <= TAP_W'(FILTER_ORDER)) begin
         coef_sel = COEF_SEL_W'(tap_ff);
      end else begin
         coef_sel = COEF_SEL_W'(tap_ff) - COEF_SEL_W'(FILTER_ORDER) + COEF_SEL_W'(COEF_A1_SEL - 1);
      end
      if (tap_ff == '0) begin
         samp_sel = x_ff;
      end else if (tap_ff <= TAP_W'(FILTER_ORDER)) begin
         samp_sel = xh_ff[xh_idx[HIDX_W-1:0]];
      end else begin
         samp_sel = yh_ff[yh_idx[HIDX_W-1:0]];
      end
   end

   // Shared multiplier operands. During the gain pass the accumulator is fed
   // in 24-bit chunks, most significant (signed) chunk first.
   always_comb begin
      if (state_ff == ST_SCALE) begin
         if (chunk_ff == '0) begin
            mul_a = {sr_ff[PAD_W-1], sr_ff[PAD_W-1 -: CHUNK_W]};
         end else begin
            mul_a = {1'b0, sr_ff[PAD_W-1 -: CHUNK_W]};
         end
         mul_b = GAIN_OP;
      end else begin
         mul_a = MUL_W'(coef_arr[coef_sel]);
         mul_b = MUL_W'(samp_sel);
      end
      prod_in = mul_a * mul_b;
   end

   // Round half up, floor shift and saturate.
   always_comb begin
      p_round = p_ff + ROUND_HALF;
      y_wide  = Y_W'(p_round >>> OUT_SHIFT);
      if (y_wide > Y_MAX) begin
         y_sat = SAMPLE_WIDTH'(Y_MAX);
      end else if (y_wide < Y_MIN) begin
         y_sat = SAMPLE_WIDTH'(Y_MIN);
      end else begin
         y_sat = SAMPLE_WIDTH'(y_wide);
      end
   end

   // Sequencer next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_be_in     = rsp_be_ff;
      tap_in        = tap_ff;
      chunk_in      = chunk_ff;
      mac_tag_in    = (state_ff == ST_MAC);
      scl_tag_in    = (state_ff == ST_SCALE);
      x_in          = x_ff;
      be_in         = be_ff;
      hist_shift    = 1'b0;
      sr_in         = sr_ff;

      // Products land in the cycle after issue, via prod_ff, and are summed as they arrive.
      if (mac_tag_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      if (scl_tag_ff) begin
         p_in = (p_ff <<< CHUNK_W) + PROD_W'(prod_ff);
      end else begin
         p_in = p_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               be_in    = req_block_end_in;
               acc_in   = '0;
               tap_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            tap_in = tap_ff + TAP_W'(1);
            if (tap_ff == TAP_W'(NTAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            sr_in    = PAD_W'(acc_in);
            p_in     = '0;
            chunk_in = '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            sr_in    = sr_ff << CHUNK_W;
            chunk_in = chunk_ff + CH_W'(1);
            if (chunk_ff == CH_W'(NCHUNK - 1)) begin
               state_in = ST_SDRAIN;
            end
         end
         ST_SDRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait here while the previous result is still stalled.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = y_sat;
               rsp_be_in     = be_ff;
               hist_shift    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mac_tag_ff   <= 1'b0;
         scl_tag_ff   <= 1'b0;
         tap_ff       <= '0;
         chunk_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mac_tag_ff   <= mac_tag_in;
         scl_tag_ff   <= scl_tag_in;
         tap_ff       <= tap_in;
         chunk_ff     <= chunk_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_be_ff     <= rsp_be_in;
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      be_ff   <= be_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      sr_ff   <= sr_in;
      p_ff    <= p_in;
   end

   // Input and output histories, newest at index 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_ORDER; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (hist_shift) begin
         xh_ff[0] <= x_ff;
         yh_ff[0] <= y_sat;
         for (int i = 1; i < FILTER_ORDER; i++) begin
            xh_ff[i] <= xh_ff[i-1];
            yh_ff[i] <= yh_ff[i-1];
         end
      end
   end

endmodule
